>>> rtl/picture_unit_register_port_unit_defines.svh
// Assertion macros for the picture unit register port RTL
`ifndef PICTURE_UNIT_REGISTER_PORT_UNIT_DEFINES_SVH
`define PICTURE_UNIT_REGISTER_PORT_UNIT_DEFINES_SVH

// Combinational or same-cycle implication property
`define PUR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Next-cycle implication: cons holds in the cycle after ante
`define PUR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/pur_pkg.sv
// Shared types and constants for the picture unit register port
package pur_pkg;

    localparam logic [2:0] REG_CTRL     = 3'd0;
    localparam logic [2:0] REG_MASK     = 3'd1;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_OAM_ADDR = 3'd3;
    localparam logic [2:0] REG_OAM_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL   = 3'd5;
    localparam logic [2:0] REG_ADDR     = 3'd6;
    localparam logic [2:0] REG_DATA     = 3'd7;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    localparam logic [1:0] VOP_NONE  = 2'd0;
    localparam logic [1:0] VOP_WRITE = 2'd1;
    localparam logic [1:0] VOP_READ  = 2'd2;

    localparam logic [7:0]  MASK_RESET = 8'h1E;
    localparam logic [14:0] STEP_COL   = 15'd1;
    localparam logic [14:0] STEP_ROW   = 15'd32;
    localparam int          CTRL_INC_BIT = 2;

    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef enum logic [3:0] {
        K_NONE,
        K_CTRL,
        K_MASK,
        K_OAM_ADDR,
        K_OAM_WR,
        K_OAM_RD,
        K_SCROLL,
        K_ADDR,
        K_DATA_WR,
        K_DATA_RD
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [1:0]  vram_op;
        logic [13:0] vram_address;
        logic [7:0]  vram_write_data;
        logic        nmi_enable;
        logic        tall_sprites;
        logic        sprite_table_high;
        logic        bg_table_high;
        logic [7:0]  render_mask;
        logic [2:0]  fine_scroll_x;
        logic [14:0] scroll_temp;
    } t_result;

endpackage

>>> rtl/pur_front.sv
// Front end: decodes bus accesses into commands and queues them for the back end
module pur_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic          i_action,
    input  logic [2:0]    i_reg_index,
    input  logic [7:0]    i_write_data,
    output logic          o_cmd_valid,
    output pur_pkg::t_cmd o_cmd,
    input  logic          i_cmd_pop
);
    import pur_pkg::*;

    t_cmd                 r_queue [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr_ptr;
    logic [CMD_PTR_W-1:0] r_rd_ptr;
    logic [CMD_CNT_W-1:0] r_count;
    logic [CMD_CNT_W-1:0] n_count;
    logic                 w_accept;
    t_cmd                 w_cmd;

    assign o_full      = (r_count == CMD_CNT_W'(CMD_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_queue[r_rd_ptr];
    assign w_accept    = i_push && !o_full;

    always_comb begin
        w_cmd.data = i_write_data;
        w_cmd.kind = K_NONE;
        if (i_action == ACT_WRITE) begin
            unique case (i_reg_index)
                REG_CTRL:     w_cmd.kind = K_CTRL;
                REG_MASK:     w_cmd.kind = K_MASK;
                REG_STATUS:   w_cmd.kind = K_NONE;
                REG_OAM_ADDR: w_cmd.kind = K_OAM_ADDR;
                REG_OAM_DATA: w_cmd.kind = K_OAM_WR;
                REG_SCROLL:   w_cmd.kind = K_SCROLL;
                REG_ADDR:     w_cmd.kind = K_ADDR;
                REG_DATA:     w_cmd.kind = K_DATA_WR;
                default:      w_cmd.kind = K_NONE;
            endcase
        end else begin
            unique case (i_reg_index)
                REG_OAM_DATA: w_cmd.kind = K_OAM_RD;
                REG_DATA:     w_cmd.kind = K_DATA_RD;
                default:      w_cmd.kind = K_NONE;
            endcase
        end
    end

    always_comb begin
        case ({w_accept, i_cmd_pop})
            2'b10:   n_count = r_count + CMD_CNT_W'(1);
            2'b01:   n_count = r_count - CMD_CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_wr_ptr <= r_wr_ptr + CMD_PTR_W'(1);
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= r_rd_ptr + CMD_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_queue[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

>>> rtl/pur_back.sv
// Back end: executes commands on the register state and sprite memory
`include "picture_unit_register_port_unit_defines.svh"
module pur_back #(
    parameter int SPRITE_MEM_BYTES = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cmd_valid,
    input  pur_pkg::t_cmd                   i_cmd,
    output logic                            o_cmd_pop,
    input  logic [pur_pkg::OUT_CNT_W-1:0]   i_out_count,
    output logic                            o_res_push,
    output pur_pkg::t_result                o_res
);
    import pur_pkg::*;

    localparam int AW = $clog2(SPRITE_MEM_BYTES);

    logic [7:0]                  r_mem [SPRITE_MEM_BYTES];
    logic [SPRITE_MEM_BYTES-1:0] r_mem_vld;
    logic [7:0]                  r_rd_data;
    logic                        r_rd_vld;

    logic [7:0]  r_ctrl,  n_ctrl;
    logic [7:0]  r_mask,  n_mask;
    logic [7:0]  r_ptr,   n_ptr;
    logic [14:0] r_temp,  n_temp;
    logic [14:0] r_cur,   n_cur;
    logic [2:0]  r_fine,  n_fine;
    logic        r_first, n_first;

    logic        r_s2_valid;
    logic        r_s2_oam_rd;
    t_result     r_s2_res;
    t_result     n_res;

    logic [AW-1:0] w_idx;
    logic [14:0]   w_step;
    logic          w_room;

    assign w_idx     = r_ptr[AW-1:0];
    assign w_step    = r_ctrl[CTRL_INC_BIT] ? STEP_ROW : STEP_COL;
    assign w_room    = (i_out_count + OUT_CNT_W'(r_s2_valid)) < OUT_CNT_W'(OUT_DEPTH);
    assign o_cmd_pop = i_cmd_valid && w_room;

    always_comb begin
        n_ctrl  = r_ctrl;
        n_mask  = r_mask;
        n_ptr   = r_ptr;
        n_temp  = r_temp;
        n_cur   = r_cur;
        n_fine  = r_fine;
        n_first = r_first;
        n_res   = '0;
        unique case (i_cmd.kind)
            K_CTRL: begin
                n_ctrl = i_cmd.data;
                n_temp = {r_temp[14:12], i_cmd.data[1:0], r_temp[9:0]};
            end
            K_MASK:     n_mask = i_cmd.data;
            K_OAM_ADDR: n_ptr  = i_cmd.data;
            K_OAM_WR:   n_ptr  = r_ptr + 8'd1;
            K_OAM_RD:   n_ptr  = r_ptr;
            K_SCROLL: begin
                if (r_first) begin
                    n_fine = i_cmd.data[2:0];
                    n_temp = {r_temp[14:5], i_cmd.data[7:3]};
                end else begin
                    n_temp = {i_cmd.data[2:0], r_temp[11:10], i_cmd.data[7:3], r_temp[4:0]};
                end
                n_first = !r_first;
            end
            K_ADDR: begin
                if (r_first) begin
                    n_temp = {1'b0, i_cmd.data[5:0], r_temp[7:0]};
                end else begin
                    n_temp = {r_temp[14:8], i_cmd.data};
                    n_cur  = {r_temp[14:8], i_cmd.data};
                end
                n_first = !r_first;
            end
            K_DATA_WR: begin
                n_res.vram_op         = VOP_WRITE;
                n_res.vram_address    = r_cur[13:0];
                n_res.vram_write_data = i_cmd.data;
                n_cur                 = r_cur + w_step;
            end
            K_DATA_RD: begin
                n_res.vram_op      = VOP_READ;
                n_res.vram_address = r_cur[13:0];
                n_cur              = r_cur + w_step;
            end
            default: n_res.vram_op = VOP_NONE;
        endcase
        n_res.nmi_enable        = n_ctrl[7];
        n_res.tall_sprites      = n_ctrl[5];
        n_res.sprite_table_high = n_ctrl[3];
        n_res.bg_table_high     = n_ctrl[4];
        n_res.render_mask       = n_mask;
        n_res.fine_scroll_x     = n_fine;
        n_res.scroll_temp       = n_temp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl     <= '0;
            r_mask     <= MASK_RESET;
            r_ptr      <= '0;
            r_temp     <= '0;
            r_cur      <= '0;
            r_fine     <= '0;
            r_first    <= 1'b1;
            r_mem_vld  <= '0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= o_cmd_pop;
            if (o_cmd_pop) begin
                r_ctrl  <= n_ctrl;
                r_mask  <= n_mask;
                r_ptr   <= n_ptr;
                r_temp  <= n_temp;
                r_cur   <= n_cur;
                r_fine  <= n_fine;
                r_first <= n_first;
                if (i_cmd.kind == K_OAM_WR) begin
                    r_mem_vld[w_idx] <= 1'b1;
                end
            end
        end
    end

    // sprite memory: one write or one registered read per beat
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && (i_cmd.kind == K_OAM_WR)) begin
            r_mem[w_idx] <= i_cmd.data;
        end
        r_rd_data <= r_mem[w_idx];
        r_rd_vld  <= r_mem_vld[w_idx];
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_s2_res    <= n_res;
            r_s2_oam_rd <= (i_cmd.kind == K_OAM_RD);
        end
    end

    always_comb begin
        o_res = r_s2_res;
        o_res.read_data = (r_s2_oam_rd && r_rd_vld) ? r_rd_data : 8'd0;
    end
    assign o_res_push = r_s2_valid;

    `PUR_ASSERT(a_pop_needs_cmd, i_clk, i_rst_n, o_cmd_pop |-> i_cmd_valid, "pop of empty queue")
    `PUR_ASSERT(a_no_overflow, i_clk, i_rst_n,
                r_s2_valid |-> (i_out_count < OUT_CNT_W'(OUT_DEPTH)),
                "result queue overflow")
    `PUR_ASSERT_NEXT(a_addr_step, i_clk, i_rst_n,
                     o_cmd_pop && (i_cmd.kind == K_DATA_WR || i_cmd.kind == K_DATA_RD),
                     (r_s2_res.vram_address + w_step[13:0]) == r_cur[13:0],
                     "address step mismatch")

endmodule

>>> rtl/pur_out_fifo.sv
// Result queue between the back end and the result ports
module pur_out_fifo (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  pur_pkg::t_result               i_res,
    input  logic                           i_pop,
    output logic                           o_empty,
    output pur_pkg::t_result               o_res,
    output logic [pur_pkg::OUT_CNT_W-1:0]  o_count
);
    import pur_pkg::*;

    t_result              r_queue [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_wr_ptr;
    logic [OUT_PTR_W-1:0] r_rd_ptr;
    logic [OUT_CNT_W-1:0] r_count;
    logic                 w_pop;

    assign o_empty = (r_count == '0);
    assign o_res   = r_queue[r_rd_ptr];
    assign o_count = r_count;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + OUT_CNT_W'(1);
                2'b01:   r_count <= r_count - OUT_CNT_W'(1);
                default: r_count <= r_count;
            endcase
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + OUT_PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + OUT_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_queue[r_wr_ptr] <= i_res;
        end
    end

endmodule

>>> rtl/picture_unit_register_port_unit.sv
// A beat passes the command queue, the back-end result register and the result queue.
// Throughput: one beat per cycle; back end stalls once held plus in-flight results reach 4.
// Sprite memory accesses use one port with registered read data.
// Reset (synchronous, active low) clears queues and registers, mask to 0x1E, toggle to first;
// per-entry valid bits make all sprite memory bytes read as zero, no clearing pass.
module picture_unit_register_port_unit #(
    parameter int SPRITE_MEM_BYTES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_action,
    input  logic [2:0]  i_reg_index,
    input  logic [7:0]  i_write_data,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_read_data,
    output logic [1:0]  o_vram_op,
    output logic [13:0] o_vram_address,
    output logic [7:0]  o_vram_write_data,
    output logic        o_nmi_enable,
    output logic        o_tall_sprites,
    output logic        o_sprite_table_high,
    output logic        o_bg_table_high,
    output logic [7:0]  o_render_mask,
    output logic [2:0]  o_fine_scroll_x,
    output logic [14:0] o_scroll_temp
);
    import pur_pkg::*;

    logic                 w_cmd_valid;
    t_cmd                 w_cmd;
    logic                 w_cmd_pop;
    logic [OUT_CNT_W-1:0] w_out_count;
    logic                 w_res_push;
    t_result              w_res_in;
    t_result              w_res_out;

    pur_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_action     (i_action),
        .i_reg_index  (i_reg_index),
        .i_write_data (i_write_data),
        .o_cmd_valid  (w_cmd_valid),
        .o_cmd        (w_cmd),
        .i_cmd_pop    (w_cmd_pop)
    );

    pur_back #(
        .SPRITE_MEM_BYTES (SPRITE_MEM_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_out_count (w_out_count),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in)
    );

    pur_out_fifo u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_res   (w_res_in),
        .i_pop   (pop),
        .o_empty (empty),
        .o_res   (w_res_out),
        .o_count (w_out_count)
    );

    assign o_read_data         = w_res_out.read_data;
    assign o_vram_op           = w_res_out.vram_op;
    assign o_vram_address      = w_res_out.vram_address;
    assign o_vram_write_data   = w_res_out.vram_write_data;
    assign o_nmi_enable        = w_res_out.nmi_enable;
    assign o_tall_sprites      = w_res_out.tall_sprites;
    assign o_sprite_table_high = w_res_out.sprite_table_high;
    assign o_bg_table_high     = w_res_out.bg_table_high;
    assign o_render_mask       = w_res_out.render_mask;
    assign o_fine_scroll_x     = w_res_out.fine_scroll_x;
    assign o_scroll_temp       = w_res_out.scroll_temp;

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the picture unit CPU register port
`timescale 1ns / 100ps

module testbench;
    import pur_pkg::*;

    class register_port_scoreboard;
        logic [7:0]  ctrl;
        logic [7:0]  mask;
        logic [7:0]  oam [256];
        logic [7:0]  oam_ptr;
        logic [14:0] t_addr;
        logic [14:0] v_addr;
        logic [2:0]  xfine;
        logic        second_write;
        t_result     pending_results [$];
        int          errors;

        function new();
            ctrl = '0;
            mask = MASK_RESET;
            foreach (oam[i]) oam[i] = '0;
            oam_ptr = '0;
            t_addr = '0;
            v_addr = '0;
            xfine = '0;
            second_write = 1'b0;
            errors = 0;
        endfunction

        function void step_vram_address();
            v_addr = v_addr + (ctrl[CTRL_INC_BIT] ? STEP_ROW : STEP_COL);
        endfunction

        function void note_access(logic act, logic [2:0] idx, logic [7:0] d);
            t_result r;
            r = '0;
            if (act == ACT_WRITE) begin
                case (idx)
                    REG_CTRL: begin
                        ctrl = d;
                        t_addr[11:10] = d[1:0];
                    end
                    REG_MASK: mask = d;
                    REG_OAM_ADDR: oam_ptr = d;
                    REG_OAM_DATA: begin
                        oam[oam_ptr] = d;
                        oam_ptr = oam_ptr + 8'd1;
                    end
                    REG_SCROLL: begin
                        if (!second_write) begin
                            xfine = d[2:0];
                            t_addr[4:0] = d[7:3];
                        end else begin
                            t_addr[14:12] = d[2:0];
                            t_addr[9:5] = d[7:3];
                        end
                        second_write = !second_write;
                    end
                    REG_ADDR: begin
                        if (!second_write) begin
                            t_addr = {1'b0, d[5:0], t_addr[7:0]};
                        end else begin
                            t_addr[7:0] = d;
                            v_addr = t_addr;
                        end
                        second_write = !second_write;
                    end
                    REG_DATA: begin
                        r.vram_op = VOP_WRITE;
                        r.vram_address = v_addr[13:0];
                        r.vram_write_data = d;
                        step_vram_address();
                    end
                    default: ;
                endcase
            end else if (idx == REG_OAM_DATA) begin
                r.read_data = oam[oam_ptr];
            end else if (idx == REG_DATA) begin
                r.vram_op = VOP_READ;
                r.vram_address = v_addr[13:0];
                step_vram_address();
            end
            r.nmi_enable = ctrl[7];
            r.tall_sprites = ctrl[5];
            r.sprite_table_high = ctrl[3];
            r.bg_table_high = ctrl[4];
            r.render_mask = mask;
            r.fine_scroll_x = xfine;
            r.scroll_temp = t_addr;
            pending_results.push_back(r);
        endfunction

        task report(string what, logic [15:0] want, logic [15:0] got);
            errors++;
            if (errors <= 100)
                $display("ERROR %0t: %s expected %h got %h", $time, what, want, got);
        endtask

        task check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                report("unexpected beat", 16'h0, 16'h0);
                return;
            end
            want = pending_results.pop_front();
            if (got.read_data !== want.read_data)
                report("read_data", want.read_data, got.read_data);
            if (got.vram_op !== want.vram_op)
                report("vram_op", want.vram_op, got.vram_op);
            if (got.vram_address !== want.vram_address)
                report("vram_address", want.vram_address, got.vram_address);
            if (got.vram_write_data !== want.vram_write_data)
                report("vram_write_data", want.vram_write_data, got.vram_write_data);
            if (got.nmi_enable !== want.nmi_enable)
                report("nmi_enable", want.nmi_enable, got.nmi_enable);
            if (got.tall_sprites !== want.tall_sprites)
                report("tall_sprites", want.tall_sprites, got.tall_sprites);
            if (got.sprite_table_high !== want.sprite_table_high)
                report("sprite_table_high", want.sprite_table_high, got.sprite_table_high);
            if (got.bg_table_high !== want.bg_table_high)
                report("bg_table_high", want.bg_table_high, got.bg_table_high);
            if (got.render_mask !== want.render_mask)
                report("render_mask", want.render_mask, got.render_mask);
            if (got.fine_scroll_x !== want.fine_scroll_x)
                report("fine_scroll_x", want.fine_scroll_x, got.fine_scroll_x);
            if (got.scroll_temp !== want.scroll_temp)
                report("scroll_temp", want.scroll_temp, got.scroll_temp);
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        i_action = 1'b0;
    logic [2:0]  i_reg_index = '0;
    logic [7:0]  i_write_data = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  o_read_data;
    logic [1:0]  o_vram_op;
    logic [13:0] o_vram_address;
    logic [7:0]  o_vram_write_data;
    logic        o_nmi_enable;
    logic        o_tall_sprites;
    logic        o_sprite_table_high;
    logic        o_bg_table_high;
    logic [7:0]  o_render_mask;
    logic [2:0]  o_fine_scroll_x;
    logic [14:0] o_scroll_temp;

    register_port_scoreboard board = new();
    int sent_count = 0;
    int popped_count = 0;
    bit send_eager = 1'b0;
    bit pop_eager = 1'b0;

    picture_unit_register_port_unit DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .push                (push),
        .full                (full),
        .i_action            (i_action),
        .i_reg_index         (i_reg_index),
        .i_write_data        (i_write_data),
        .empty               (empty),
        .pop                 (pop),
        .o_read_data         (o_read_data),
        .o_vram_op           (o_vram_op),
        .o_vram_address      (o_vram_address),
        .o_vram_write_data   (o_vram_write_data),
        .o_nmi_enable        (o_nmi_enable),
        .o_tall_sprites      (o_tall_sprites),
        .o_sprite_table_high (o_sprite_table_high),
        .o_bg_table_high     (o_bg_table_high),
        .o_render_mask       (o_render_mask),
        .o_fine_scroll_x     (o_fine_scroll_x),
        .o_scroll_temp       (o_scroll_temp)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    task send_access(logic act, logic [2:0] idx, logic [7:0] d);
        int gap;
        if (sent_count % 50 == 0)
            send_eager = ($urandom_range(0, 3) == 0);
        gap = send_eager ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_action <= act;
        i_reg_index <= idx;
        i_write_data <= d;
        do @(posedge i_clk); while (full !== 1'b0);
        board.note_access(act, idx, d);
        sent_count++;
    endtask

    task send_noise();
        send_access(1'($urandom), 3'($urandom), 8'($urandom));
    endtask

    // result side: random pops, two long hold-offs to back the block up
    initial begin
        int gap;
        t_result got;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (popped_count % 40 == 0)
                pop_eager = ($urandom_range(0, 3) == 0);
            if (popped_count == 300 || popped_count == 1400)
                gap = 150;
            else
                gap = pop_eager ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty !== 1'b0);
            got.read_data = o_read_data;
            got.vram_op = o_vram_op;
            got.vram_address = o_vram_address;
            got.vram_write_data = o_vram_write_data;
            got.nmi_enable = o_nmi_enable;
            got.tall_sprites = o_tall_sprites;
            got.sprite_table_high = o_sprite_table_high;
            got.bg_table_high = o_bg_table_high;
            got.render_mask = o_render_mask;
            got.fine_scroll_x = o_fine_scroll_x;
            got.scroll_temp = o_scroll_temp;
            board.check_result(got);
            popped_count++;
        end
    end

    initial begin
        #2_000_000;
        $display("picture_unit_register_port_unit: mismatch");
        $finish;
    end

    initial begin
        int n;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values, status and write-only reads
        send_access(ACT_READ, REG_OAM_DATA, 8'h00);
        send_access(ACT_READ, REG_DATA, 8'hFF);
        send_access(ACT_READ, REG_STATUS, 8'h00);
        send_access(ACT_WRITE, REG_STATUS, 8'hFF);
        send_access(ACT_READ, REG_CTRL, 8'hFF);
        send_access(ACT_READ, REG_MASK, 8'hFF);
        send_access(ACT_READ, REG_OAM_ADDR, 8'hFF);
        send_access(ACT_READ, REG_SCROLL, 8'hFF);
        send_access(ACT_READ, REG_ADDR, 8'hFF);
        // row increment, all control bits
        send_access(ACT_WRITE, REG_CTRL, 8'hFF);
        send_access(ACT_WRITE, REG_MASK, 8'h00);
        send_access(ACT_WRITE, REG_DATA, 8'hA5);
        // sprite pointer wraps after a data write at the top slot
        send_access(ACT_WRITE, REG_OAM_ADDR, 8'hFF);
        send_access(ACT_WRITE, REG_OAM_DATA, 8'h5A);
        send_access(ACT_READ, REG_OAM_DATA, 8'h00);
        send_access(ACT_WRITE, REG_OAM_ADDR, 8'hFF);
        send_access(ACT_READ, REG_OAM_DATA, 8'h00);
        // build current address 0x7FFF through the shared toggle, then wrap
        send_access(ACT_WRITE, REG_CTRL, 8'h03);
        send_access(ACT_WRITE, REG_ADDR, 8'h3F);
        send_access(ACT_WRITE, REG_SCROLL, 8'hFF);
        send_access(ACT_WRITE, REG_SCROLL, 8'hFF);
        send_access(ACT_WRITE, REG_ADDR, 8'hFF);
        send_access(ACT_WRITE, REG_DATA, 8'h00);
        send_access(ACT_READ, REG_DATA, 8'h00);
        send_access(ACT_WRITE, REG_MASK, 8'hFF);
        send_access(ACT_WRITE, REG_CTRL, 8'h00);

        while (sent_count < 1975) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    if ($urandom_range(0, 1))
                        send_access(ACT_WRITE, REG_CTRL, 8'($urandom));
                    send_access(ACT_WRITE, REG_ADDR, 8'($urandom));
                    send_access(ACT_WRITE, REG_ADDR, 8'($urandom));
                    n = $urandom_range(1, 8);
                    repeat (n) send_access(1'($urandom), REG_DATA, 8'($urandom));
                end
                2: begin
                    send_access(ACT_WRITE, REG_SCROLL, 8'($urandom));
                    send_access(ACT_WRITE, REG_SCROLL, 8'($urandom));
                end
                3: begin
                    send_access(ACT_WRITE, REG_OAM_ADDR, 8'($urandom));
                    n = $urandom_range(1, 8);
                    repeat (n) send_access(ACT_WRITE, REG_OAM_DATA, 8'($urandom));
                end
                4: begin
                    send_access(ACT_WRITE, REG_OAM_ADDR, 8'($urandom));
                    n = $urandom_range(1, 4);
                    repeat (n) send_access(1'($urandom), REG_OAM_DATA, 8'($urandom));
                end
                5: begin
                    send_access(ACT_WRITE, REG_CTRL, 8'($urandom));
                    send_access(ACT_WRITE, REG_MASK, 8'($urandom));
                end
                6, 7: begin
                    n = $urandom_range(1, 4);
                    repeat (n) send_noise();
                end
                8: begin
                    n = $urandom_range(1, 16);
                    repeat (n) send_access(1'($urandom), REG_DATA, 8'($urandom));
                end
                default: begin
                    // lone toggle write leaves the pair out of step
                    send_access(ACT_WRITE, $urandom_range(0, 1) ? REG_SCROLL : REG_ADDR,
                                8'($urandom));
                    send_noise();
                end
            endcase
        end
        push <= 1'b0;

        while (board.pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (board.errors == 0)
            $display("picture_unit_register_port_unit: match");
        else
            $display("picture_unit_register_port_unit: mismatch");
        $finish;
    end

endmodule
